// ----- sv/mwm_pkg.sv -----
// Shared types and constants for the mecanum wheel mixer.
// Used by every module of the block; depends on nothing else.

package mwm_pkg;

	localparam int VelW        = 16;  // signed Q4.12 velocity command
	localparam int CfgW        = 16;  // unsigned Q4.12 geometry register
	localparam int CfgIdxW     = 1;   // two geometry registers
	localparam int KW          = 17;  // unsigned Q5.12 geometry sum
	localparam int WheelW      = 34;  // signed Q.24 raw wheel sum
	localparam int MagW        = 33;  // magnitude of a raw wheel sum
	localparam int RemW        = 48;  // divider partial remainder
	localparam int QuoW        = 15;  // wheel speed magnitude, up to 1.0 in Q.14
	localparam int SpeedW      = 16;  // signed Q2.14 wheel speed
	localparam int NumWheels   = 4;
	localparam int DivSteps    = 15;  // one quotient bit per divider stage
	localparam int FracShift   = 14;
	localparam int BypassW     = 25;  // unscaled magnitude plus rounding bias
	localparam int QDepth      = 8;
	localparam int QPtrW       = 3;
	localparam int QCntW       = 4;
	localparam int FrontStages = 4;

	localparam logic [MagW-1:0]        OneQ24    = MagW'(33'd16777216);
	localparam logic [BypassW-1:0]     RoundHalf = BypassW'(25'd512);
	localparam logic [CfgW-1:0]        GeomReset = CfgW'(16'd4096);
	localparam logic signed [SpeedW-1:0] SpeedOne = SpeedW'(16'sd16384);

	// Wheel order in all arrays.
	localparam int WhlFl = 0;
	localparam int WhlFr = 1;
	localparam int WhlRl = 2;
	localparam int WhlRr = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_WHEEL_BASE  = 1'b0,
		REG_TRACK_GAUGE = 1'b1
	} mwm_reg_t;

	// One classified command as it travels from the front to the back.
	typedef struct packed {
		logic [NumWheels-1:0]           neg;
		logic [NumWheels-1:0][MagW-1:0] mag;
		logic [MagW-1:0]                peak;
	} mwm_item_t;

	typedef struct packed {
		logic not_empty;
		logic almost_full;
	} mwm_qstat_t;

endpackage

// ----- sv/mwm_front.sv -----
// Front end of the mecanum wheel mixer: geometry registers, mix and peak search.
// Depends on mwm_pkg.

module mwm_front import mwm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [CfgW-1:0]          cfg_data,
	input  logic                     accept,
	input  logic signed [VelW-1:0]   forward_velocity,
	input  logic signed [VelW-1:0]   sideways_velocity,
	input  logic signed [VelW-1:0]   rotation_velocity,
	output logic                     push,
	output mwm_item_t                item
);

	logic [CfgW-1:0] wheel_base_q, track_gauge_q;
	logic [CfgW-1:0] wb_nxt, tg_nxt;
	logic [KW-1:0]   k_q;

	logic                     vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [VelW-1:0]   fwd_s1, side_s1;
	logic signed [WheelW-1:0] rot_s1;
	logic signed [WheelW-1:0] w_s2 [NumWheels];
	logic [NumWheels-1:0]     neg_s3;
	logic [MagW-1:0]          mag_s3 [NumWheels];
	mwm_item_t                item_s4;

	logic signed [WheelW-1:0] vx, vy;
	logic signed [WheelW-1:0] w_neg [NumWheels];
	logic [MagW-1:0]          m01, m23;

	always_comb begin
		wb_nxt = wheel_base_q;
		tg_nxt = track_gauge_q;
		if (cfg_write) begin
			unique case (mwm_reg_t'(cfg_index))
				REG_WHEEL_BASE:  wb_nxt = cfg_data;
				REG_TRACK_GAUGE: tg_nxt = cfg_data;
			endcase
		end
	end

	// The geometry sum is kept ready so the multiplier sees a register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_base_q  <= GeomReset;
			track_gauge_q <= GeomReset;
			k_q           <= {1'b0, GeomReset} + {1'b0, GeomReset};
		end else begin
			wheel_base_q  <= wb_nxt;
			track_gauge_q <= tg_nxt;
			k_q           <= {1'b0, wb_nxt} + {1'b0, tg_nxt};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_comb begin
		vx = {{(WheelW-VelW-12){fwd_s1[VelW-1]}}, fwd_s1, 12'b0};
		vy = {{(WheelW-VelW-12){side_s1[VelW-1]}}, side_s1, 12'b0};
		for (int i = 0; i < NumWheels; i++) begin
			w_neg[i] = -w_s2[i];
		end
		m01 = (mag_s3[WhlFl] > mag_s3[WhlFr]) ? mag_s3[WhlFl] : mag_s3[WhlFr];
		m23 = (mag_s3[WhlRl] > mag_s3[WhlRr]) ? mag_s3[WhlRl] : mag_s3[WhlRr];
	end

	always_ff @(posedge clk) begin
		// Stage 1: rotation term, the only multiply.
		fwd_s1  <= forward_velocity;
		side_s1 <= sideways_velocity;
		rot_s1  <= WheelW'(rotation_velocity) * WheelW'($signed({1'b0, k_q}));
		// Stage 2: the four mixes, exact in Q.24.
		w_s2[WhlFl] <= vx - vy - rot_s1;
		w_s2[WhlFr] <= vx + vy + rot_s1;
		w_s2[WhlRl] <= vx + vy - rot_s1;
		w_s2[WhlRr] <= vx - vy + rot_s1;
		// Stage 3: sign and magnitude.
		for (int i = 0; i < NumWheels; i++) begin
			neg_s3[i] <= w_s2[i][WheelW-1];
			mag_s3[i] <= w_s2[i][WheelW-1] ? w_neg[i][MagW-1:0] : w_s2[i][MagW-1:0];
		end
		// Stage 4: largest magnitude.
		item_s4.neg  <= neg_s3;
		for (int i = 0; i < NumWheels; i++) begin
			item_s4.mag[i] <= mag_s3[i];
		end
		item_s4.peak <= (m01 > m23) ? m01 : m23;
	end

	assign push = vld_s4;
	assign item = item_s4;

endmodule

// ----- sv/mwm_queue.sv -----
// Short command queue between the front and back of the wheel mixer.
// Depends on mwm_pkg.

module mwm_queue import mwm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  mwm_item_t  wr_item,
	input  logic       pop,
	output mwm_item_t  rd_item,
	output mwm_qstat_t stat
);

	mwm_item_t        mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCntW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rd_item          = mem_q[rd_ptr_q];
	assign stat.not_empty   = (count_q != '0);
	// Leave room for every command still inside the front end.
	assign stat.almost_full = (count_q >= QCntW'(QDepth - FrontStages));

endmodule

// ----- sv/mwm_back.sv -----
// Back end of the wheel mixer: rounding, pipelined normalizing divide, sign.
// Depends on mwm_pkg.

module mwm_back import mwm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     take,
	input  mwm_item_t                item,
	output logic                     done,
	output logic signed [SpeedW-1:0] front_left_speed,
	output logic signed [SpeedW-1:0] front_right_speed,
	output logic signed [SpeedW-1:0] rear_left_speed,
	output logic signed [SpeedW-1:0] rear_right_speed
);

	logic [DivSteps:0]     vld_s;
	logic [NumWheels-1:0]  neg_s   [DivSteps+1];
	logic [QuoW-1:0]       quo_s   [DivSteps+1][NumWheels];
	logic [DivSteps-1:0]   scale_s;
	logic [MagW-1:0]       peak_s  [DivSteps];
	logic [RemW-1:0]       rem_s   [DivSteps][NumWheels];

	logic                  scale_in;
	logic [RemW-1:0]       rem_in  [NumWheels];
	logic [QuoW-1:0]       quo_in  [NumWheels];
	logic [BypassW-1:0]    biased  [NumWheels];

	logic                     done_q;
	logic signed [SpeedW-1:0] spd_q [NumWheels];
	logic [SpeedW-1:0]        spd_pos [NumWheels];

	// Entry: unscaled speeds are just rounded here; scaled ones get the
	// rounded dividend mag * 2^14 + peak / 2.
	always_comb begin
		scale_in = (item.peak > OneQ24);
		for (int i = 0; i < NumWheels; i++) begin
			biased[i] = item.mag[i][BypassW-1:0] + RoundHalf;
			rem_in[i] = scale_in
				? ((RemW'(item.mag[i]) << FracShift) + RemW'(item.peak >> 1))
				: '0;
			quo_in[i] = scale_in ? '0 : biased[i][BypassW-1:10];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[DivSteps-1:0], take};
		end
	end

	always_ff @(posedge clk) begin
		scale_s[0] <= scale_in;
		peak_s[0]  <= item.peak;
		neg_s[0]   <= item.neg;
		for (int i = 0; i < NumWheels; i++) begin
			rem_s[0][i] <= rem_in[i];
			quo_s[0][i] <= quo_in[i];
		end
	end

	// Restoring division, most significant quotient bit first.
	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		localparam int Bit = DivSteps - 1 - j;
		logic [RemW-1:0] divisor;
		logic [RemW:0]   diff   [NumWheels];
		logic [RemW-1:0] rem_nx [NumWheels];
		logic [QuoW-1:0] quo_nx [NumWheels];

		always_comb begin
			divisor = RemW'(peak_s[j]) << Bit;
			for (int i = 0; i < NumWheels; i++) begin
				diff[i]   = {1'b0, rem_s[j][i]} - {1'b0, divisor};
				rem_nx[i] = rem_s[j][i];
				quo_nx[i] = quo_s[j][i];
				if (scale_s[j] && !diff[i][RemW]) begin
					rem_nx[i]      = diff[i][RemW-1:0];
					quo_nx[i][Bit] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			neg_s[j+1] <= neg_s[j];
			for (int i = 0; i < NumWheels; i++) begin
				quo_s[j+1][i] <= quo_nx[i];
			end
		end

		if (j < DivSteps - 1) begin : g_fwd
			always_ff @(posedge clk) begin
				scale_s[j+1] <= scale_s[j];
				peak_s[j+1]  <= peak_s[j];
				for (int i = 0; i < NumWheels; i++) begin
					rem_s[j+1][i] <= rem_nx[i];
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NumWheels; i++) begin
			spd_pos[i] = {1'b0, quo_s[DivSteps][i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NumWheels; i++) begin
			spd_q[i] <= neg_s[DivSteps][i] ? -$signed(spd_pos[i]) : $signed(spd_pos[i]);
		end
	end

	assign done              = done_q;
	assign front_left_speed  = spd_q[WhlFl];
	assign front_right_speed = spd_q[WhlFr];
	assign rear_left_speed   = spd_q[WhlRl];
	assign rear_right_speed  = spd_q[WhlRr];

endmodule

// ----- sv/mecanum_wheel_mixer_core.sv -----
// Mecanum wheel mixer, top level: front end, command queue and divider back end.
// Depends on mwm_pkg, mwm_front, mwm_queue and mwm_back.
// A taken command is delivered with done high after passing through 4 front,
// 1 queue, 16 divider and 1 output stage.
// Throughput: one command per cycle, one divider stage per quotient bit; busy never rises.
// The receiver cannot stall. Reset clears all control state and sets both geometries to 1.0.

module mecanum_wheel_mixer_core import mwm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write,
	input  logic [CfgIdxW-1:0]       cfg_index,
	input  logic [CfgW-1:0]          cfg_data,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [VelW-1:0]   forward_velocity,
	input  logic signed [VelW-1:0]   sideways_velocity,
	input  logic signed [VelW-1:0]   rotation_velocity,
	output logic                     done,
	output logic signed [SpeedW-1:0] front_left_speed,
	output logic signed [SpeedW-1:0] front_right_speed,
	output logic signed [SpeedW-1:0] rear_left_speed,
	output logic signed [SpeedW-1:0] rear_right_speed
);

	// A command transfer happens when start is high and busy is low.
	logic       accept;
	logic       push;
	mwm_item_t  front_item;
	mwm_item_t  back_item;
	mwm_qstat_t qstat;

	// The back end never stalls, so the queue holds at most one entry in
	// practice; busy only rises if the queue could not absorb every command
	// still inside the front end.
	assign busy   = qstat.almost_full;
	assign accept = start && !busy;

	// The front end owns the geometry registers. It mixes the command into
	// four raw wheel sums and finds the largest magnitude.
	mwm_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.accept            (accept),
		.forward_velocity  (forward_velocity),
		.sideways_velocity (sideways_velocity),
		.rotation_velocity (rotation_velocity),
		.push              (push),
		.item              (front_item)
	);

	// The queue decouples the two halves; it is popped whenever it holds data.
	mwm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.pop     (qstat.not_empty),
		.rd_item (back_item),
		.stat    (qstat)
	);

	// The back end either rounds the sums down to Q2.14 or, when the peak
	// exceeds 1.0, divides every magnitude by the peak with rounding.
	mwm_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.take              (qstat.not_empty),
		.item              (back_item),
		.done              (done),
		.front_left_speed  (front_left_speed),
		.front_right_speed (front_right_speed),
		.rear_left_speed   (rear_left_speed),
		.rear_right_speed  (rear_right_speed)
	);

	// Every delivered result traces back to a command transfer a fixed time ago.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 22))
		else $error("result without a matching command");

	// Normalization keeps every speed within plus or minus one.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (front_left_speed  >= -SpeedOne && front_left_speed  <= SpeedOne &&
		          front_right_speed >= -SpeedOne && front_right_speed <= SpeedOne &&
		          rear_left_speed   >= -SpeedOne && rear_left_speed   <= SpeedOne &&
		          rear_right_speed  >= -SpeedOne && rear_right_speed  <= SpeedOne))
		else $error("wheel speed beyond unit magnitude");

endmodule

// ----- verif/mecanum_wheel_mixer_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the mecanum wheel mixer core.
// Depends on mwm_pkg and mecanum_wheel_mixer_core; predicts each wheel set in fixed point.

module mecanum_wheel_mixer_core_tb;
	import mwm_pkg::*;

	localparam int SETTLE_CYCLES = 4;     // quiet cycles before a geometry write
	localparam int DRAIN_CYCLES  = 40;    // idle margin after the last expected wheel set
	localparam int STALL_LIMIT   = 1000;  // cycles without any transfer before giving up
	localparam int CALM_TAIL     = 150;   // no idling once this few commands remain
	localparam int RANDOM_PER_SET = 220;

	localparam longint unsigned UNITY_Q24 = 64'd1 << 24;

	typedef enum logic {
		ITEM_MIX,
		ITEM_GEOM
	} item_kind_t;

	// One entry of the stimulus queue: either a velocity command or a geometry write.
	typedef struct {
		item_kind_t              kind;
		mwm_reg_t                reg_sel;
		logic [CfgW-1:0]         geom;
		logic signed [VelW-1:0]  fwd;
		logic signed [VelW-1:0]  side;
		logic signed [VelW-1:0]  rot;
	} stim_item_t;

	// Expected wheel set; normalized marks commands that needed the divide.
	typedef struct {
		logic signed [SpeedW-1:0] fl;
		logic signed [SpeedW-1:0] fr;
		logic signed [SpeedW-1:0] rl;
		logic signed [SpeedW-1:0] rr;
		bit                       normalized;
	} wheel_mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0] cfg_data = '0;
	logic start = 1'b0;
	logic signed [VelW-1:0] forward_velocity = '0;
	logic signed [VelW-1:0] sideways_velocity = '0;
	logic signed [VelW-1:0] rotation_velocity = '0;
	logic busy;
	logic done;
	logic signed [SpeedW-1:0] front_left_speed;
	logic signed [SpeedW-1:0] front_right_speed;
	logic signed [SpeedW-1:0] rear_left_speed;
	logic signed [SpeedW-1:0] rear_right_speed;

	// Mirror of the geometry registers, as loaded by reset.
	logic [CfgW-1:0] geo_base = 16'd4096;
	logic [CfgW-1:0] geo_gauge = 16'd4096;

	stim_item_t command_queue[$];
	wheel_mix_t pending_speeds[$];

	int mismatches = 0;
	int transfers = 0;
	int results_seen = 0;
	int scaled_count = 0;
	int geometry_sets = 1;

	mecanum_wheel_mixer_core dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.start             (start),
		.busy              (busy),
		.forward_velocity  (forward_velocity),
		.sideways_velocity (sideways_velocity),
		.rotation_velocity (rotation_velocity),
		.done              (done),
		.front_left_speed  (front_left_speed),
		.front_right_speed (front_right_speed),
		.rear_left_speed   (rear_left_speed),
		.rear_right_speed  (rear_right_speed)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 0;
	end

	// Reduce one raw Q.24 wheel sum to a Q2.14 speed. Without scaling the sum is
	// rounded to nearest with ties away from zero; with scaling it is divided by
	// the peak magnitude, again rounded on the magnitude before the sign returns.
	function automatic logic [SpeedW-1:0] scale_wheel(input longint raw,
			input longint unsigned peak);
		longint unsigned mag;
		longint unsigned quo;
		mag = (raw < 0) ? longint'(-raw) : raw;
		if (peak > UNITY_Q24)
			quo = ((mag << FracShift) + (peak >> 1)) / peak;
		else
			quo = (mag + 64'd512) >> 10;
		if (raw < 0)
			quo = -quo;
		return quo[SpeedW-1:0];
	endfunction

	// Inverse kinematics with the current geometry mirror. All sums are exact in
	// 64 bits: the largest raw term is about 2^32.
	function automatic wheel_mix_t mix_wheels(input logic signed [VelW-1:0] fwd,
			input logic signed [VelW-1:0] side, input logic signed [VelW-1:0] rot);
		wheel_mix_t res;
		longint vx;
		longint vy;
		longint spin;
		longint raw[NumWheels];
		longint unsigned peak;
		longint unsigned mag;
		vx = longint'(fwd) * 4096;
		vy = longint'(side) * 4096;
		spin = longint'(rot) * (longint'(geo_base) + longint'(geo_gauge));
		raw[WhlFl] = vx - vy - spin;
		raw[WhlFr] = vx + vy + spin;
		raw[WhlRl] = vx + vy - spin;
		raw[WhlRr] = vx - vy + spin;
		peak = 0;
		for (int i = 0; i < NumWheels; i++) begin
			mag = (raw[i] < 0) ? longint'(-raw[i]) : raw[i];
			if (mag > peak)
				peak = mag;
		end
		res.fl = scale_wheel(raw[WhlFl], peak);
		res.fr = scale_wheel(raw[WhlFr], peak);
		res.rl = scale_wheel(raw[WhlRl], peak);
		res.rr = scale_wheel(raw[WhlRr], peak);
		res.normalized = (peak > UNITY_Q24);
		return res;
	endfunction

	task automatic check_field(input string field, input logic signed [SpeedW-1:0] want,
			input logic signed [SpeedW-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			mismatches++;
		end
	endtask

	task automatic push_mix(input int fwd, input int side, input int rot);
		stim_item_t it;
		it.kind = ITEM_MIX;
		it.reg_sel = REG_WHEEL_BASE;
		it.geom = '0;
		it.fwd = VelW'(fwd);
		it.side = VelW'(side);
		it.rot = VelW'(rot);
		command_queue.push_back(it);
	endtask

	// A new geometry setting writes both registers; each write waits for an idle block.
	task automatic push_geometry(input int base, input int gauge);
		stim_item_t it;
		it.kind = ITEM_GEOM;
		it.fwd = '0;
		it.side = '0;
		it.rot = '0;
		it.reg_sel = REG_WHEEL_BASE;
		it.geom = CfgW'(base);
		command_queue.push_back(it);
		it.reg_sel = REG_TRACK_GAUGE;
		it.geom = CfgW'(gauge);
		command_queue.push_back(it);
		geometry_sets++;
	endtask

	// Velocity mix: full-width noise for bit coverage, small values that stay
	// below unity, mid-range values, and the usual corner values.
	function automatic int rand_velocity();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = int'($signed(VelW'($urandom)));
			4, 5, 6: v = $urandom_range(0, 2048);
			7: begin
				case ($urandom_range(0, 6))
					0: v = 32767;
					1: v = -32768;
					2: v = 0;
					3: v = 4096;
					4: v = -4096;
					5: v = 1;
					default: v = -1;
				endcase
			end
			default: v = $urandom_range(0, 8192);
		endcase
		if (v > 0 && v <= 8192 && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	function automatic int rand_geometry();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 65535;
			2, 3: return $urandom_range(0, 8192);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	task automatic push_random_mixes(input int count);
		repeat (count)
			push_mix(rand_velocity(), rand_velocity(), rand_velocity());
	endtask

	// Driver. At each rising edge it first books what the edge moved (a geometry
	// write or a command transfer), then picks what to drive in the next cycle.
	// Geometry writes wait until every outstanding wheel set has come back.
	always @(posedge clk) begin : drive
		logic next_start;
		logic next_cfg;
		int gap_left;
		int settle;
		bit calm;
		stim_item_t head;
		wheel_mix_t mix;
		if (arst_n) begin
			next_start = start;
			next_cfg = 1'b0;
			if (cfg_write) begin
				case (mwm_reg_t'(cfg_index))
					REG_WHEEL_BASE: geo_base = cfg_data;
					REG_TRACK_GAUGE: geo_gauge = cfg_data;
				endcase
				transfers++;
			end
			if (start && !busy) begin
				mix = mix_wheels(forward_velocity, sideways_velocity, rotation_velocity);
				pending_speeds.push_back(mix);
				if (mix.normalized)
					scaled_count++;
				transfers++;
				next_start = 1'b0;
			end
			if (!next_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (command_queue.size() != 0) begin
					head = command_queue[0];
					if (head.kind == ITEM_GEOM) begin
						if (pending_speeds.size() != 0 || cfg_write) begin
							settle = 0;
						end else if (settle < SETTLE_CYCLES) begin
							settle++;
						end else begin
							void'(command_queue.pop_front());
							next_cfg = 1'b1;
							cfg_index <= head.reg_sel;
							cfg_data <= head.geom;
							settle = 0;
						end
					end else begin
						// Stretches without any idling come and go at random.
						if ($urandom_range(0, 39) == 0)
							calm = !calm;
						if (!calm && command_queue.size() > CALM_TAIL
								&& $urandom_range(0, 3) == 0) begin
							gap_left = $urandom_range(1, 9) - 1;
						end else begin
							void'(command_queue.pop_front());
							forward_velocity <= head.fwd;
							sideways_velocity <= head.side;
							rotation_velocity <= head.rot;
							next_start = 1'b1;
						end
					end
				end
			end
			start <= next_start;
			cfg_write <= next_cfg;
		end
	end

	// Monitor. A wheel set is valid only in the cycle where done is high, so it
	// is taken at the edge that ends that cycle and matched against the oldest
	// expected set.
	always @(posedge clk) begin : observe
		wheel_mix_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_speeds.size() == 0) begin
				$error("wheel set with no command outstanding: %0d %0d %0d %0d",
					front_left_speed, front_right_speed, rear_left_speed, rear_right_speed);
				mismatches++;
			end else begin
				want = pending_speeds.pop_front();
				check_field("front_left_speed", want.fl, front_left_speed);
				check_field("front_right_speed", want.fr, front_right_speed);
				check_field("rear_left_speed", want.rl, rear_left_speed);
				check_field("rear_right_speed", want.rr, rear_right_speed);
			end
		end
	end

	// Watchdog: any command, geometry write or wheel set counts as progress.
	always @(posedge clk) begin : watchdog
		int last_seen;
		int stalled;
		if (arst_n) begin
			if (transfers + results_seen != last_seen) begin
				last_seen = transfers + results_seen;
				stalled = 0;
			end else begin
				stalled++;
				if (stalled >= STALL_LIMIT) begin
					$error("no transfer for %0d cycles", STALL_LIMIT);
					$display("TB_ERROR");
					$finish;
				end
			end
		end
	end

	initial begin
		// Directed commands at the reset geometry (k = 2.0): field extremes,
		// a command of exactly unity that must pass unscaled, one just above
		// unity that must be normalized, and small values that exercise rounding.
		push_mix(0, 0, 0);
		push_mix(32767, 0, 0);
		push_mix(-32768, 0, 0);
		push_mix(0, 32767, 0);
		push_mix(0, -32768, 0);
		push_mix(0, 0, 32767);
		push_mix(0, 0, -32768);
		push_mix(32767, 32767, 32767);
		push_mix(-32768, -32768, -32768);
		push_mix(4096, 0, 0);
		push_mix(4097, 0, 0);
		push_mix(1, -1, 0);
		push_mix(2048, -1024, 512);

		// Zero geometry: rotation must have no effect at all.
		push_geometry(0, 0);
		push_mix(0, 0, 32767);
		push_mix(4096, 0, -32768);
		push_mix(100, -200, -32768);
		push_random_mixes(RANDOM_PER_SET);

		// Largest geometry, where the rotation term dominates.
		push_geometry(65535, 65535);
		push_mix(32767, -32768, -32768);
		push_mix(0, 0, 1);
		push_mix(-32768, 32767, 32767);
		push_random_mixes(RANDOM_PER_SET);

		// k = 0.125: a unit rotation lands exactly on a rounding tie.
		push_geometry(512, 0);
		push_mix(0, 0, 1);
		push_mix(0, 0, -1);
		push_mix(0, 0, 3);
		push_random_mixes(200);

		repeat (4) begin
			push_geometry(rand_geometry(), rand_geometry());
			push_random_mixes(RANDOM_PER_SET);
		end

		push_geometry(4096, 4096);
		push_random_mixes(RANDOM_PER_SET);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (command_queue.size() != 0 || start || cfg_write || pending_speeds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_speeds.size() != 0) begin
			$error("%0d wheel sets never arrived", pending_speeds.size());
			mismatches += pending_speeds.size();
		end

		$display("Checked %0d wheel sets over %0d geometry settings, %0d of them normalized.",
			results_seen, geometry_sets, scaled_count);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
